### design/tnq_pkg.sv
// shared types and constants for the ticket notify queue
// no dependencies; imported by every module of the block
package tnq_pkg;

  localparam int unsigned ID_W        = 8;
  localparam int unsigned TICKET_W    = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned MAX_OUT     = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_OUT);
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_WAIT       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NOTIFY_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NOTIFY_ALL = 2'd2;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_NOTIFY_ONE,
    OP_NOTIFY_ALL
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED = 3'd0,
    KIND_PARKED  = 3'd1,
    KIND_WOKEN   = 3'd2,
    KIND_NONE    = 3'd3,
    KIND_FULL    = 3'd4
  } kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_DRAIN
  } bk_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  waiter_id;
  } tnq_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     who;
    logic [TICKET_W-1:0] ticket;
    logic                last;
  } tnq_out_t;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
  } tnq_op_t;

endpackage

### design/ticket_notify_queue.sv
// top level of the ticket notify queue: front decode, command queue, back stage
// depends on tnq_pkg, tnq_front, tnq_queue, tnq_back
//
// channels: commands come in on in_valid_i / in_stall_o / in_data_i (cmd, waiter_id);
// results leave on out_valid_o / out_stall_i / out_data_o (kind, who, ticket, last).
// a transfer happens at a clock edge with valid high and stall low.
// a wait takes the next ticket and is granted at once, parked in a free slot,
// or refused when the table is full; a notify-one advances the next counter and
// wakes the waiter holding that ticket; a notify-all wakes every parked waiter,
// lowest slot first, at most sixteen per command, with last on the final result.
// path: a result passes the front register, a queue entry and the output register
// before it is valid.
// throughput: one wait or notify-one per cycle while the output is not stalled and no
// drain runs; a notify-all gives one result per waiter woken, all through the single result register of the back stage.
// cmd 3 is dropped in the front and gives no result.
// reset clears both counters, all slot valid bits, the queue and the output.
// a stalled output holds its result; the queue then fills and the input stalls.
module ticket_notify_queue import tnq_pkg::*; #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tnq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tnq_out_t out_data_o
);

  // decoded command from the front register
  logic    f_valid;
  tnq_op_t f_op;

  // queue state seen by both sides
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  tnq_op_t q_head;

  tnq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .op_valid_o (f_valid),
    .op_full_i  (q_full),
    .op_o       (f_op)
  );

  // decouples decode from execution so a long drain does not block the input at once
  tnq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_op),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .head_o      (q_head)
  );

  // counters, waiter table and the registered result
  tnq_back #(
    .SLOTS       (SLOTS),
    .TICKET_BITS (TICKET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_head),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/tnq_front.sv
// front stage: takes input transfers, decodes the command, drops unknown codes
// depends on tnq_pkg
module tnq_front import tnq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  tnq_in_t in_data_i,
  output logic    op_valid_o,
  input  logic    op_full_i,
  output tnq_op_t op_o
);

  logic    f_valid_q, f_valid_d;
  tnq_op_t f_op_q, f_op_d;
  logic    push;
  logic    take;
  logic    known;
  op_e     dec_op;

  assign push       = f_valid_q && !op_full_i;
  assign in_stall_o = f_valid_q && op_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign op_valid_o = f_valid_q;
  assign op_o       = f_op_q;

  always_comb begin
    known  = 1'b1;
    dec_op = OP_WAIT;
    case (in_data_i.cmd)
      CMD_WAIT:       dec_op = OP_WAIT;
      CMD_NOTIFY_ONE: dec_op = OP_NOTIFY_ONE;
      CMD_NOTIFY_ALL: dec_op = OP_NOTIFY_ALL;
      default:        known  = 1'b0;
    endcase
  end

  always_comb begin
    f_valid_d = f_valid_q && !push;
    f_op_d    = f_op_q;
    if (take) begin
      f_valid_d = known;
      f_op_d.op = dec_op;
      f_op_d.id = in_data_i.waiter_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_op_q <= f_op_d;
  end

endmodule

### design/tnq_queue.sv
// short command queue between the front and back stages
// depends on tnq_pkg
module tnq_queue import tnq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  tnq_op_t push_data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    pop_i,
  output tnq_op_t head_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  tnq_op_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // occupancy never goes past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

### design/tnq_back.sv
// back stage: ticket counters, waiter table, notify-all drain and output register
// depends on tnq_pkg
module tnq_back import tnq_pkg::*; #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned TICKET_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     op_valid_i,
  input  tnq_op_t  op_i,
  output logic     op_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tnq_out_t out_data_o
);

  localparam int unsigned SIdxW = $clog2(SLOTS);

  bk_state_e              state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [TICKET_BITS-1:0] wait_q, wait_d;
  logic [TICKET_BITS-1:0] next_q, next_d;
  logic [SLOTS-1:0]       valid_q;
  logic [ID_W-1:0]        waiter_q [SLOTS];
  logic [TICKET_BITS-1:0] ticket_q [SLOTS];

  logic                   out_valid_q, out_valid_d;
  tnq_out_t               out_q, out_d;

  logic                   load;
  logic                   eq;
  logic [TICKET_BITS-1:0] diff;
  logic                   free_hit, any_valid, match_hit, others;
  logic [SIdxW-1:0]       free_idx, first_idx, match_idx;
  logic                   park_en, clr_en, drain_step, lst;
  logic [SIdxW-1:0]       park_idx, clr_idx;
  logic [CNT_W-1:0]       cnt_use;

  assign load        = !out_valid_q || !out_stall_i;
  assign eq          = (wait_q == next_q);
  assign diff        = wait_q - next_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // lowest free slot, lowest parked slot, lowest slot holding the next ticket
  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    any_valid = 1'b0;
    first_idx = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_hit = 1'b1;
        free_idx = SIdxW'(i);
      end
      if (valid_q[i]) begin
        any_valid = 1'b1;
        first_idx = SIdxW'(i);
      end
      if (valid_q[i] && ticket_q[i] == next_q) begin
        match_hit = 1'b1;
        match_idx = SIdxW'(i);
      end
    end
  end

  always_comb begin
    others = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_q[i] && SIdxW'(i) != first_idx) begin
        others = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    wait_d      = wait_q;
    next_d      = next_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    op_pop_o    = 1'b0;
    park_en     = 1'b0;
    park_idx    = free_idx;
    clr_en      = 1'b0;
    clr_idx     = first_idx;
    drain_step  = 1'b0;
    cnt_use     = '0;
    lst         = 1'b0;

    case (state_q)
      BK_IDLE: begin
        if (op_valid_i && load) begin
          op_pop_o     = 1'b1;
          out_valid_d  = 1'b1;
          out_d.last   = 1'b1;
          out_d.who    = op_i.id;
          out_d.ticket = TICKET_W'(wait_q);
          case (op_i.op)
            OP_WAIT: begin
              if (diff[TICKET_BITS-1]) begin
                out_d.kind = KIND_GRANTED;
                wait_d     = wait_q + 1'b1;
              end else if (free_hit) begin
                out_d.kind = KIND_PARKED;
                park_en    = 1'b1;
                wait_d     = wait_q + 1'b1;
              end else begin
                out_d.kind = KIND_FULL;
              end
            end
            OP_NOTIFY_ONE: begin
              out_d.kind   = KIND_NONE;
              out_d.who    = '0;
              out_d.ticket = TICKET_W'(next_q);
              if (!eq) begin
                next_d = next_q + 1'b1;
                if (match_hit) begin
                  out_d.kind = KIND_WOKEN;
                  out_d.who  = waiter_q[match_idx];
                  clr_en     = 1'b1;
                  clr_idx    = match_idx;
                end
              end
            end
            OP_NOTIFY_ALL: begin
              out_d.kind   = KIND_NONE;
              out_d.who    = '0;
              out_d.ticket = TICKET_W'(next_q);
              if (!eq) begin
                if (any_valid) begin
                  drain_step = 1'b1;
                end else begin
                  next_d = wait_q;
                end
              end
            end
            default: begin
              out_valid_d = 1'b0;
            end
          endcase
        end
      end
      BK_DRAIN: begin
        if (load) begin
          drain_step = 1'b1;
          cnt_use    = cnt_q;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // one parked waiter woken per step, capped per command
    if (drain_step) begin
      lst          = (cnt_use == CNT_W'(MAX_OUT - 1)) || !others;
      out_valid_d  = 1'b1;
      out_d.kind   = KIND_WOKEN;
      out_d.who    = waiter_q[first_idx];
      out_d.ticket = TICKET_W'(ticket_q[first_idx]);
      out_d.last   = lst;
      clr_en       = 1'b1;
      clr_idx      = first_idx;
      if (lst) begin
        state_d = BK_IDLE;
        cnt_d   = '0;
        if (!others) begin
          next_d = wait_q;
        end
      end else begin
        state_d = BK_DRAIN;
        cnt_d   = cnt_use + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      wait_q      <= '0;
      next_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wait_q      <= wait_d;
      next_q      <= next_d;
      out_valid_q <= out_valid_d;
      if (park_en) begin
        valid_q[park_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_q[clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (park_en) begin
      waiter_q[park_idx] <= op_i.id;
      ticket_q[park_idx] <= wait_q;
    end
  end

  // a drain only runs while something is still parked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRAIN |-> |valid_q)
    else $error("drain with empty table");

  // no command is taken from the queue mid-drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DRAIN |-> !op_pop_o)
    else $error("pop during drain");

  // a stalled result is held until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");

endmodule

### bench/tb_ticket_notify_queue.sv
// self-checking bench for ticket_notify_queue: directed table, then random command mixes
// keeps its own ticket and slot bookkeeping to predict results not typed by hand; needs tnq_pkg and the rtl
module tb_ticket_notify_queue import tnq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_N       = 16;
  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RAND_ITEMS   = 170;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // the one command code the package leaves unnamed: dropped by the block
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // one row of the directed table; typed rows carry their result written out by hand
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    logic             typed;
    logic             has_res;
    tnq_out_t         res;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  tnq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  tnq_out_t out_data_o;

  // predicted block state
  logic [TICKET_W-1:0] issued_tkt;
  logic [TICKET_W-1:0] served_tkt;
  logic                slot_busy [SLOT_N];
  logic [ID_W-1:0]     slot_who  [SLOT_N];
  logic [TICKET_W-1:0] slot_tkt  [SLOT_N];

  tnq_out_t cmd_outcomes [$];   // results of the command just predicted
  tnq_out_t due_results  [$];   // results still to come out of the block, oldest first

  int unsigned mismatches  = 0;
  int unsigned rand_items  = 0;
  bit          steady      = 1'b0;
  bit          hold_wanted = 1'b0;
  bit          hold_done   = 1'b0;

  always #(CLK_HALF) clk_i = ~clk_i;

  ticket_notify_queue #(
    .SLOTS       (SLOT_N),
    .TICKET_BITS (TICKET_W)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  function automatic tnq_out_t make_result(kind_e k, logic [ID_W-1:0] w,
                                           logic [TICKET_W-1:0] t, logic l);
    tnq_out_t r;
    r.kind   = k;
    r.who    = w;
    r.ticket = t;
    r.last   = l;
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                       logic typed, logic has_res, kind_e k,
                                       logic [ID_W-1:0] w, logic [TICKET_W-1:0] t,
                                       logic l);
    dir_row_t r;
    r.cmd     = cmd;
    r.id      = id;
    r.typed   = typed;
    r.has_res = has_res;
    r.res     = make_result(k, w, t, l);
    return r;
  endfunction

  function automatic void clear_tickets();
    issued_tkt = '0;
    served_tkt = '0;
    for (int i = 0; i < SLOT_N; i++) begin
      slot_busy[i] = 1'b0;
      slot_who[i]  = '0;
      slot_tkt[i]  = '0;
    end
  endfunction

  // works out what one accepted command does to the tickets and the slot table
  function automatic void predict_outcome(tnq_in_t c);
    logic [TICKET_W-1:0] t;
    logic [TICKET_W-1:0] ahead;
    int                  pick;
    int                  woken;
    bit                  left_over;
    tnq_out_t            tail;
    cmd_outcomes.delete();
    pick      = -1;
    woken     = 0;
    left_over = 1'b0;
    case (c.cmd)
      CMD_WAIT: begin
        t     = issued_tkt;
        ahead = t - served_tkt;
        if (ahead[TICKET_W-1]) begin
          // ticket already served: granted without parking
          issued_tkt = t + 1'b1;
          cmd_outcomes.push_back(make_result(KIND_GRANTED, c.waiter_id, t, 1'b1));
        end else begin
          for (int i = 0; i < SLOT_N; i++)
            if (pick < 0 && !slot_busy[i]) pick = i;
          if (pick >= 0) begin
            slot_busy[pick] = 1'b1;
            slot_who[pick]  = c.waiter_id;
            slot_tkt[pick]  = t;
            issued_tkt      = t + 1'b1;
            cmd_outcomes.push_back(make_result(KIND_PARKED, c.waiter_id, t, 1'b1));
          end else begin
            // table full: the ticket is not consumed
            cmd_outcomes.push_back(make_result(KIND_FULL, c.waiter_id, t, 1'b1));
          end
        end
      end
      CMD_NOTIFY_ONE, CMD_NOTIFY_ALL: begin
        if (issued_tkt == served_tkt) begin
          cmd_outcomes.push_back(make_result(KIND_NONE, '0, served_tkt, 1'b1));
        end else if (c.cmd == CMD_NOTIFY_ONE) begin
          t          = served_tkt;
          served_tkt = t + 1'b1;
          for (int i = 0; i < SLOT_N; i++)
            if (pick < 0 && slot_busy[i] && slot_tkt[i] == t) pick = i;
          if (pick >= 0) begin
            slot_busy[pick] = 1'b0;
            cmd_outcomes.push_back(make_result(KIND_WOKEN, slot_who[pick], t, 1'b1));
          end else begin
            cmd_outcomes.push_back(make_result(KIND_NONE, '0, t, 1'b1));
          end
        end else begin
          // lowest slot first, capped at the per-command result limit
          for (int i = 0; i < SLOT_N; i++) begin
            if (slot_busy[i]) begin
              if (woken >= MAX_OUT) begin
                left_over = 1'b1;
              end else begin
                slot_busy[i] = 1'b0;
                cmd_outcomes.push_back(make_result(KIND_WOKEN, slot_who[i], slot_tkt[i],
                                                   1'b0));
                woken++;
              end
            end
          end
          if (woken == 0) begin
            cmd_outcomes.push_back(make_result(KIND_NONE, '0, served_tkt, 1'b1));
          end else begin
            tail      = cmd_outcomes.pop_back();
            tail.last = 1'b1;
            cmd_outcomes.push_back(tail);
          end
          if (!left_over) served_tkt = issued_tkt;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // sender gaps: mostly back to back or short, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // offers one command and, once the transfer has happened, books its results
  task automatic offer_command(input tnq_in_t c, input logic typed, input logic has_res,
                               input tnq_out_t typed_res);
    int unsigned gap;
    gap = pick_gap();
    // valid only drops when a gap follows, so it is never lowered and raised in one step
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    predict_outcome(c);
    if (typed) begin
      if (has_res) due_results.push_back(typed_res);
    end else begin
      while (cmd_outcomes.size() > 0) due_results.push_back(cmd_outcomes.pop_front());
    end
  endtask

  task automatic offer_random(input logic [CMD_W-1:0] cmd);
    tnq_in_t c;
    c.cmd       = cmd;
    c.waiter_id = ID_W'($urandom_range(0, 255));
    offer_command(c, 1'b0, 1'b0, '0);
    // dropped commands do not count towards the random total
    if (cmd != CMD_NONE) rand_items++;
  endtask

  // stimulus: reset, directed table, then random command mixes
  initial begin : stimulus
    dir_row_t    dir_tab [$];
    tnq_in_t     c;
    int unsigned burst;
    int unsigned mix;
    clear_tickets();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // counters equal after reset: both notify flavours find nothing to wake
    dir_tab.push_back(dir_row(CMD_NOTIFY_ONE, 8'h00, 1'b1, 1'b1, KIND_NONE, 8'h00, 16'd0, 1'b1));
    dir_tab.push_back(dir_row(CMD_NOTIFY_ALL, 8'hFF, 1'b1, 1'b1, KIND_NONE, 8'h00, 16'd0, 1'b1));
    // unknown command is swallowed without a result
    dir_tab.push_back(dir_row(CMD_NONE, 8'h5A, 1'b1, 1'b0, KIND_NONE, 8'h00, 16'd0, 1'b0));
    // two parks with extreme ids, then wake them one way and the other
    dir_tab.push_back(dir_row(CMD_WAIT, 8'h00, 1'b1, 1'b1, KIND_PARKED, 8'h00, 16'd0, 1'b1));
    dir_tab.push_back(dir_row(CMD_WAIT, 8'hFF, 1'b1, 1'b1, KIND_PARKED, 8'hFF, 16'd1, 1'b1));
    dir_tab.push_back(dir_row(CMD_NOTIFY_ONE, 8'hA5, 1'b1, 1'b1, KIND_WOKEN, 8'h00, 16'd0,
                              1'b1));
    dir_tab.push_back(dir_row(CMD_NOTIFY_ALL, 8'h00, 1'b0, 1'b0, KIND_NONE, 8'h00, 16'd0, 1'b0));
    dir_tab.push_back(dir_row(CMD_NOTIFY_ONE, 8'h00, 1'b1, 1'b1, KIND_NONE, 8'h00, 16'd2, 1'b1));
    // fill every slot, walking a one and then a zero through the id
    for (int k = 0; k < SLOT_N; k++)
      dir_tab.push_back(dir_row(CMD_WAIT, (k < 8) ? (8'h01 << k) : ~(8'h01 << (k - 8)),
                                1'b0, 1'b0, KIND_NONE, 8'h00, 16'd0, 1'b0));
    // table full: refused, ticket not consumed
    dir_tab.push_back(dir_row(CMD_WAIT, 8'h3C, 1'b1, 1'b1, KIND_FULL, 8'h3C, 16'd18, 1'b1));
    // notify-all on a full table: sixteen wakes, last on the final one
    dir_tab.push_back(dir_row(CMD_NOTIFY_ALL, 8'hC3, 1'b0, 1'b0, KIND_NONE, 8'h00, 16'd0, 1'b0));

    foreach (dir_tab[i]) begin
      c.cmd       = dir_tab[i].cmd;
      c.waiter_id = dir_tab[i].id;
      offer_command(c, dir_tab[i].typed, dir_tab[i].has_res, dir_tab[i].res);
    end

    // random part: mostly park bursts followed by wakes, some noise in between
    while (rand_items < RAND_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      if (rand_items >= 40) hold_wanted = 1'b1;
      mix = $urandom_range(0, 9);
      if (mix <= 5) begin
        burst = $urandom_range(1, SLOT_N + 2);
        repeat (burst) offer_random(CMD_WAIT);
        repeat ($urandom_range(0, burst + 2)) offer_random(CMD_NOTIFY_ONE);
      end else if (mix <= 7) begin
        burst = $urandom_range(0, SLOT_N + 2);
        repeat (burst) offer_random(CMD_WAIT);
        offer_random(CMD_NOTIFY_ALL);
      end else if (mix == 8) begin
        offer_random(CMD_W'($urandom_range(0, 3)));
      end else begin
        offer_random(CMD_NOTIFY_ALL);
      end
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // allow for a stray result still in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver stall: random segments of free flow and hold-off, plus one long hold
  // while the sender keeps offering, so the internal queue fills and the input stalls
  initial begin : result_backpressure
    int unsigned stall_left;
    int unsigned free_left;
    stall_left = 0;
    free_left  = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && free_left == 0) begin
        if (hold_wanted && !hold_done) begin
          hold_done  = 1'b1;
          stall_left = HOLD_CYCLES;
        end else begin
          case ($urandom_range(0, 9))
            0:       free_left  = $urandom_range(30, 80);
            1:       stall_left = $urandom_range(15, 50);
            default: stall_left = $urandom_range(0, 3);
          endcase
          free_left = free_left + $urandom_range(1, 6);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        free_left--;
        out_stall_i <= 1'b0;
      end
    end
  end

  // result check: every transfer on the output is matched against the oldest due result
  initial begin : result_check
    tnq_out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          flag_mismatch("result with nothing due", 32'(out_data_o), 0);
        end else begin
          want = due_results.pop_front();
          if (out_data_o.kind !== want.kind)
            flag_mismatch("kind", 32'(out_data_o.kind), 32'(want.kind));
          if (out_data_o.who !== want.who)
            flag_mismatch("who", 32'(out_data_o.who), 32'(want.who));
          if (out_data_o.ticket !== want.ticket)
            flag_mismatch("ticket", 32'(out_data_o.ticket), 32'(want.ticket));
          if (out_data_o.last !== want.last)
            flag_mismatch("last", 32'(out_data_o.last), 32'(want.last));
        end
      end
    end
  end

  // generous ceiling: far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### ticket_notify_queue.f
design/tnq_pkg.sv
design/tnq_front.sv
design/tnq_queue.sv
design/tnq_back.sv
design/ticket_notify_queue.sv
bench/tb_ticket_notify_queue.sv
